>>> rtl/c6502_pkg.sv
package c6502_pkg;

    typedef enum logic [6:0] {
        ACT_LDA = 7'd0,
        ACT_LDX, ACT_LDY, ACT_STA, ACT_STY, ACT_STX,
        ACT_TAX, ACT_TAY, ACT_TXA, ACT_TYA, ACT_TSX, ACT_TXS,
        ACT_PHA, ACT_PHP, ACT_PLA, ACT_PLP,
        ACT_AND, ACT_EOR, ACT_ORA, ACT_BIT, ACT_ADC, ACT_SBC,
        ACT_CMP, ACT_CPX, ACT_CPY,
        ACT_DEC, ACT_DEX, ACT_DEY, ACT_INC, ACT_INX, ACT_INY,
        ACT_ASL, ACT_LSR, ACT_ROL, ACT_ROR,
        ACT_BCC, ACT_BCS, ACT_BEQ, ACT_BMI, ACT_BNE, ACT_BPL, ACT_BVC, ACT_BVS,
        ACT_CLC, ACT_CLD, ACT_CLI, ACT_CLV, ACT_SEC, ACT_SED, ACT_SEI, ACT_NOP,
        ACT_ALR, ACT_ANC, ACT_ARR, ACT_AXS, ACT_LAX, ACT_SAX,
        ACT_DCP, ACT_ISB, ACT_RLA, ACT_RRA, ACT_SLO, ACT_SRE,
        ACT_SHY, ACT_SHX
    } t_action;

    // Status bit positions, NV-BDIZC.
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] FLAGS_BU       = 8'h30;
    localparam logic [7:0] STATUS_RESET   = 8'h24;
    localparam logic [7:0] STACK_RESET    = 8'hFD;

    typedef struct packed {
        logic [6:0] action;
        logic [7:0] operand;
        logic       on_accumulator;
        logic [7:0] address_high;
    } t_in_item;

    typedef struct packed {
        logic [7:0] accumulator;
        logic [7:0] index_x;
        logic [7:0] index_y;
        logic [7:0] status;
        logic [7:0] stack_pointer;
        logic       write_enable;
        logic [7:0] write_data;
        logic [7:0] write_high;
        logic       stack_access;
        logic [7:0] stack_slot;
        logic       branch_taken;
    } t_out_item;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] sp;
    } t_cpu_state;

endpackage

>>> rtl/c6502_regs.sv
module c6502_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  c6502_pkg::t_cpu_state i_next,
    output c6502_pkg::t_cpu_state o_state
);

    c6502_pkg::t_cpu_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.acc <= 8'h00;
            r_state.x   <= 8'h00;
            r_state.y   <= 8'h00;
            r_state.p   <= c6502_pkg::STATUS_RESET;
            r_state.sp  <= c6502_pkg::STACK_RESET;
        end else if (i_load) begin
            r_state <= i_next;
        end
    end

    assign o_state = r_state;

endmodule

>>> rtl/c6502_alu.sv
module c6502_alu (
    input  c6502_pkg::t_cpu_state i_state,
    input  c6502_pkg::t_in_item   i_item,
    output c6502_pkg::t_cpu_state o_state,
    output c6502_pkg::t_out_item  o_result
);

    function automatic logic [7:0] f_zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[c6502_pkg::FLAG_Z] = (v == 8'h00);
        q[c6502_pkg::FLAG_N] = v[7];
        return q;
    endfunction

    function automatic logic [7:0] f_cmp(input logic [7:0] p, input logic [7:0] r,
                                         input logic [7:0] m);
        logic [7:0] q;
        logic [7:0] d;
        d = r - m;
        q = f_zn(p, d);
        q[c6502_pkg::FLAG_C] = (r >= m);
        return q;
    endfunction

    // Returns {V, C, sum}.
    function automatic logic [9:0] f_adc(input logic [7:0] a, input logic [7:0] m,
                                         input logic ci);
        logic [8:0] sum;
        logic       ov;
        sum = {1'b0, a} + {1'b0, m} + {8'd0, ci};
        ov  = (a[7] ^ sum[7]) & (m[7] ^ sum[7]);
        return {ov, sum};
    endfunction

    function automatic logic [7:0] f_adc_flags(input logic [7:0] p, input logic [9:0] r);
        logic [7:0] q;
        q = f_zn(p, r[7:0]);
        q[c6502_pkg::FLAG_C] = r[8];
        q[c6502_pkg::FLAG_V] = r[9];
        return q;
    endfunction

    // Shifts return {carry out, result}.
    function automatic logic [8:0] f_shl(input logic [7:0] v, input logic ci);
        return {v[7], v[6:0], ci};
    endfunction

    function automatic logic [8:0] f_shr(input logic [7:0] v, input logic ci);
        return {v[0], ci, v[7:1]};
    endfunction

    function automatic logic [7:0] f_sh_flags(input logic [7:0] p, input logic [8:0] r);
        logic [7:0] q;
        q = f_zn(p, r[7:0]);
        q[c6502_pkg::FLAG_C] = r[8];
        return q;
    endfunction

    always_comb begin
        c6502_pkg::t_cpu_state ns;
        logic [7:0] m;
        logic [7:0] src;
        logic [7:0] t;
        logic [7:0] hi_inc;
        logic [8:0] sh;
        logic [9:0] sum;
        logic       c;
        logic       we;
        logic [7:0] wd;
        logic [7:0] wh;
        logic       sa;
        logic [7:0] slot;
        logic       br;

        ns     = i_state;
        m      = i_item.operand;
        c      = i_state.p[c6502_pkg::FLAG_C];
        src    = i_item.on_accumulator ? i_state.acc : m;
        hi_inc = i_item.address_high + 8'd1;
        t      = 8'h00;
        sh     = 9'd0;
        sum    = 10'd0;
        we     = 1'b0;
        wd     = 8'h00;
        wh     = i_item.address_high;
        sa     = 1'b0;
        slot   = 8'h00;
        br     = 1'b0;

        case (i_item.action)
            c6502_pkg::ACT_LDA: begin
                ns.acc = m;
                ns.p   = f_zn(i_state.p, m);
            end
            c6502_pkg::ACT_LDX: begin
                ns.x = m;
                ns.p = f_zn(i_state.p, m);
            end
            c6502_pkg::ACT_LDY: begin
                ns.y = m;
                ns.p = f_zn(i_state.p, m);
            end
            c6502_pkg::ACT_STA: begin
                we = 1'b1;
                wd = i_state.acc;
            end
            c6502_pkg::ACT_STY: begin
                we = 1'b1;
                wd = i_state.y;
            end
            c6502_pkg::ACT_STX: begin
                we = 1'b1;
                wd = i_state.x;
            end
            c6502_pkg::ACT_TAX: begin
                ns.x = i_state.acc;
                ns.p = f_zn(i_state.p, i_state.acc);
            end
            c6502_pkg::ACT_TAY: begin
                ns.y = i_state.acc;
                ns.p = f_zn(i_state.p, i_state.acc);
            end
            c6502_pkg::ACT_TXA: begin
                ns.acc = i_state.x;
                ns.p   = f_zn(i_state.p, i_state.x);
            end
            c6502_pkg::ACT_TYA: begin
                ns.acc = i_state.y;
                ns.p   = f_zn(i_state.p, i_state.y);
            end
            c6502_pkg::ACT_TSX: begin
                ns.x = i_state.sp;
                ns.p = f_zn(i_state.p, i_state.sp);
            end
            c6502_pkg::ACT_TXS: begin
                ns.sp = i_state.x;
            end
            c6502_pkg::ACT_PHA, c6502_pkg::ACT_PHP: begin
                we    = 1'b1;
                sa    = 1'b1;
                slot  = i_state.sp;
                wd    = (i_item.action == c6502_pkg::ACT_PHA) ? i_state.acc
                                                              : (i_state.p | c6502_pkg::FLAGS_BU);
                ns.sp = i_state.sp - 8'd1;
            end
            c6502_pkg::ACT_PLA: begin
                ns.sp  = i_state.sp + 8'd1;
                sa     = 1'b1;
                slot   = ns.sp;
                ns.acc = m;
                ns.p   = f_zn(i_state.p, m);
            end
            c6502_pkg::ACT_PLP: begin
                ns.sp = i_state.sp + 8'd1;
                sa    = 1'b1;
                slot  = ns.sp;
                // The break and unused bits are not restored from the stack.
                ns.p  = (i_state.p & c6502_pkg::FLAGS_BU) | (m & ~c6502_pkg::FLAGS_BU);
            end
            c6502_pkg::ACT_AND: begin
                ns.acc = i_state.acc & m;
                ns.p   = f_zn(i_state.p, ns.acc);
            end
            c6502_pkg::ACT_EOR: begin
                ns.acc = i_state.acc ^ m;
                ns.p   = f_zn(i_state.p, ns.acc);
            end
            c6502_pkg::ACT_ORA: begin
                ns.acc = i_state.acc | m;
                ns.p   = f_zn(i_state.p, ns.acc);
            end
            c6502_pkg::ACT_BIT: begin
                ns.p[c6502_pkg::FLAG_Z] = ((m & i_state.acc) == 8'h00);
                ns.p[c6502_pkg::FLAG_N] = m[7];
                ns.p[c6502_pkg::FLAG_V] = m[6];
            end
            c6502_pkg::ACT_ADC: begin
                sum    = f_adc(i_state.acc, m, c);
                ns.acc = sum[7:0];
                ns.p   = f_adc_flags(i_state.p, sum);
            end
            c6502_pkg::ACT_SBC: begin
                sum    = f_adc(i_state.acc, ~m, c);
                ns.acc = sum[7:0];
                ns.p   = f_adc_flags(i_state.p, sum);
            end
            c6502_pkg::ACT_CMP: ns.p = f_cmp(i_state.p, i_state.acc, m);
            c6502_pkg::ACT_CPX: ns.p = f_cmp(i_state.p, i_state.x, m);
            c6502_pkg::ACT_CPY: ns.p = f_cmp(i_state.p, i_state.y, m);
            c6502_pkg::ACT_DEC: begin
                we   = 1'b1;
                wd   = m - 8'd1;
                ns.p = f_zn(i_state.p, wd);
            end
            c6502_pkg::ACT_DEX: begin
                ns.x = i_state.x - 8'd1;
                ns.p = f_zn(i_state.p, ns.x);
            end
            c6502_pkg::ACT_DEY: begin
                ns.y = i_state.y - 8'd1;
                ns.p = f_zn(i_state.p, ns.y);
            end
            c6502_pkg::ACT_INC: begin
                we   = 1'b1;
                wd   = m + 8'd1;
                ns.p = f_zn(i_state.p, wd);
            end
            c6502_pkg::ACT_INX: begin
                ns.x = i_state.x + 8'd1;
                ns.p = f_zn(i_state.p, ns.x);
            end
            c6502_pkg::ACT_INY: begin
                ns.y = i_state.y + 8'd1;
                ns.p = f_zn(i_state.p, ns.y);
            end
            c6502_pkg::ACT_ASL, c6502_pkg::ACT_LSR, c6502_pkg::ACT_ROL,
            c6502_pkg::ACT_ROR: begin
                case (i_item.action)
                    c6502_pkg::ACT_ASL: sh = f_shl(src, 1'b0);
                    c6502_pkg::ACT_LSR: sh = f_shr(src, 1'b0);
                    c6502_pkg::ACT_ROL: sh = f_shl(src, c);
                    default:            sh = f_shr(src, c);
                endcase
                ns.p = f_sh_flags(i_state.p, sh);
                if (i_item.on_accumulator) begin
                    ns.acc = sh[7:0];
                end else begin
                    we = 1'b1;
                    wd = sh[7:0];
                end
            end
            c6502_pkg::ACT_BCC: br = !c;
            c6502_pkg::ACT_BCS: br = c;
            c6502_pkg::ACT_BEQ: br = i_state.p[c6502_pkg::FLAG_Z];
            c6502_pkg::ACT_BMI: br = i_state.p[c6502_pkg::FLAG_N];
            c6502_pkg::ACT_BNE: br = !i_state.p[c6502_pkg::FLAG_Z];
            c6502_pkg::ACT_BPL: br = !i_state.p[c6502_pkg::FLAG_N];
            c6502_pkg::ACT_BVC: br = !i_state.p[c6502_pkg::FLAG_V];
            c6502_pkg::ACT_BVS: br = i_state.p[c6502_pkg::FLAG_V];
            c6502_pkg::ACT_CLC: ns.p[c6502_pkg::FLAG_C] = 1'b0;
            c6502_pkg::ACT_CLD: ns.p[c6502_pkg::FLAG_D] = 1'b0;
            c6502_pkg::ACT_CLI: ns.p[c6502_pkg::FLAG_I] = 1'b0;
            c6502_pkg::ACT_CLV: ns.p[c6502_pkg::FLAG_V] = 1'b0;
            c6502_pkg::ACT_SEC: ns.p[c6502_pkg::FLAG_C] = 1'b1;
            c6502_pkg::ACT_SED: ns.p[c6502_pkg::FLAG_D] = 1'b1;
            c6502_pkg::ACT_SEI: ns.p[c6502_pkg::FLAG_I] = 1'b1;
            c6502_pkg::ACT_ALR: begin
                sh     = f_shr(i_state.acc & m, 1'b0);
                ns.acc = sh[7:0];
                ns.p   = f_sh_flags(i_state.p, sh);
            end
            c6502_pkg::ACT_ANC: begin
                ns.acc = i_state.acc & m;
                ns.p   = f_zn(i_state.p, ns.acc);
                ns.p[c6502_pkg::FLAG_C] = ns.acc[7];
            end
            c6502_pkg::ACT_ARR: begin
                t      = i_state.acc & m;
                t      = {c, t[7:1]};
                ns.acc = t;
                ns.p   = f_zn(i_state.p, t);
                ns.p[c6502_pkg::FLAG_C] = t[6];
                ns.p[c6502_pkg::FLAG_V] = t[6] ^ t[5];
            end
            c6502_pkg::ACT_AXS: begin
                t    = i_state.x & i_state.acc;
                ns.p = f_cmp(i_state.p, t, m);
                ns.x = t - m;
            end
            c6502_pkg::ACT_LAX: begin
                ns.acc = m;
                ns.x   = m;
                ns.p   = f_zn(i_state.p, m);
            end
            c6502_pkg::ACT_SAX: begin
                we = 1'b1;
                wd = i_state.acc & i_state.x;
            end
            c6502_pkg::ACT_DCP: begin
                we   = 1'b1;
                wd   = m - 8'd1;
                ns.p = f_cmp(i_state.p, i_state.acc, wd);
            end
            c6502_pkg::ACT_ISB: begin
                we     = 1'b1;
                wd     = m + 8'd1;
                sum    = f_adc(i_state.acc, ~wd, c);
                ns.acc = sum[7:0];
                ns.p   = f_adc_flags(i_state.p, sum);
            end
            c6502_pkg::ACT_RLA: begin
                sh     = f_shl(m, c);
                we     = 1'b1;
                wd     = sh[7:0];
                ns.acc = i_state.acc & sh[7:0];
                ns.p   = f_sh_flags(i_state.p, {sh[8], ns.acc});
            end
            c6502_pkg::ACT_RRA: begin
                // The add takes its carry from the rotate, not from the old status.
                sh     = f_shr(m, c);
                we     = 1'b1;
                wd     = sh[7:0];
                sum    = f_adc(i_state.acc, sh[7:0], sh[8]);
                ns.acc = sum[7:0];
                ns.p   = f_adc_flags(i_state.p, sum);
            end
            c6502_pkg::ACT_SLO: begin
                sh     = f_shl(m, 1'b0);
                we     = 1'b1;
                wd     = sh[7:0];
                ns.acc = i_state.acc | sh[7:0];
                ns.p   = f_sh_flags(i_state.p, {sh[8], ns.acc});
            end
            c6502_pkg::ACT_SRE: begin
                sh     = f_shr(m, 1'b0);
                we     = 1'b1;
                wd     = sh[7:0];
                ns.acc = i_state.acc ^ sh[7:0];
                ns.p   = f_sh_flags(i_state.p, {sh[8], ns.acc});
            end
            c6502_pkg::ACT_SHY: begin
                we = 1'b1;
                wd = i_state.y & hi_inc;
                wh = wd;
            end
            c6502_pkg::ACT_SHX: begin
                we = 1'b1;
                wd = i_state.x & hi_inc;
                wh = wd;
            end
            default: begin
            end
        endcase

        o_state                = ns;
        o_result.accumulator   = ns.acc;
        o_result.index_x       = ns.x;
        o_result.index_y       = ns.y;
        o_result.status        = ns.p;
        o_result.stack_pointer = ns.sp;
        o_result.write_enable  = we;
        o_result.write_data    = wd;
        o_result.write_high    = wh;
        o_result.stack_access  = sa;
        o_result.stack_slot    = slot;
        o_result.branch_taken  = br;
    end

endmodule

>>> rtl/cpu6502_execute_unit.sv
// Execute stage of a 6502: accumulator, index registers, status and stack
// pointer with the ALU that updates them.
// Input channel: i_in_valid / o_in_stall carry one decoded operation per
// transaction, with its fetched or pulled operand byte, the accumulator-mode
// bit for shifts and the high byte of the effective address.
// Output channel: o_out_valid / i_out_stall carry one result per operation:
// all registers after the operation, any memory or stack write and the
// branch condition.
// An accepted operation is first captured in the input register; the ALU then writes the
// register file and the result register together, which raises o_out_valid. Throughput
// is one operation per cycle while the receiver does not stall; the register file loop
// (state read, ALU, state write) is combinational from the register file's output back
// to its input.
// When the receiver stalls, the result register holds its transaction, the
// next operation waits in the input register, and o_in_stall rises only once
// both are full and the receiver is still stalling.
// Synchronous reset clears both stages and sets A = X = Y = 0,
// status = 0x24 and stack pointer = 0xFD.
module cpu6502_execute_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  c6502_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output c6502_pkg::t_out_item o_out_item
);

    logic                  r_in_valid;
    c6502_pkg::t_in_item   r_in_item;
    logic                  r_out_valid;
    c6502_pkg::t_out_item  r_out_item;
    logic                  w_advance;
    logic                  w_in_take;
    c6502_pkg::t_cpu_state w_state;
    c6502_pkg::t_cpu_state w_next_state;
    c6502_pkg::t_out_item  w_result;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    c6502_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_next  (w_next_state),
        .o_state (w_state)
    );

    c6502_alu u_alu (
        .i_state  (w_state),
        .i_item   (r_in_item),
        .o_state  (w_next_state),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("executed operation did not reach the result register");

    a_state_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(w_state))
        else $error("register file changed without an executed operation");

    a_waiting_op_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_item))
        else $error("waiting operation was lost or overwritten");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_item.accumulator == w_state.acc
                   && r_out_item.stack_pointer == w_state.sp
                   && r_out_item.status == w_state.p)
        else $error("result registers disagree with the register file");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

endmodule

>>> bench/cpu6502_execute_unit_test.sv
`timescale 1ns / 1ps

module cpu6502_execute_unit_test;

    localparam int RANDOM_OPS      = 1250;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int PRINT_LIMIT     = 60;
    localparam logic [6:0] ACT_UNUSED_LOW = 7'd65;
    localparam logic [6:0] ACT_UNUSED_TOP = 7'd127;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    c6502_pkg::t_in_item  in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    c6502_pkg::t_out_item out_item;

    cpu6502_execute_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    c6502_pkg::t_in_item  op_queue[$];
    c6502_pkg::t_out_item expected_results[$];

    // Predicted architectural registers.
    logic [7:0] reg_a, reg_x, reg_y, reg_p, reg_s;

    int errors = 0;
    int ops_accepted = 0;
    int results_checked = 0;
    int branches_taken = 0;
    int writes_seen = 0;
    int directed_ops = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_cycle = 0;
    int idle_cycles = 0;
    bit [127:0] codes_seen = '0;

    task automatic report_error(input string msg);
        if (errors < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want, input int index);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %02h, expected %02h",
                                   index, name, got, want));
    endtask

    function automatic void set_nz(input logic [7:0] v);
        reg_p[c6502_pkg::FLAG_Z] = (v == 8'h00);
        reg_p[c6502_pkg::FLAG_N] = v[7];
    endfunction

    function automatic void add_with_carry(input logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, reg_p[c6502_pkg::FLAG_C]};
        reg_p[c6502_pkg::FLAG_C] = sum[8];
        reg_p[c6502_pkg::FLAG_V] = (reg_a[7] ^ sum[7]) & (m[7] ^ sum[7]);
        reg_a = sum[7:0];
        set_nz(reg_a);
    endfunction

    function automatic void compare_with(input logic [7:0] r, input logic [7:0] m);
        reg_p[c6502_pkg::FLAG_C] = (r >= m);
        set_nz(r - m);
    endfunction

    function automatic logic [7:0] shift_left(input logic [7:0] v, input logic cin);
        reg_p[c6502_pkg::FLAG_C] = v[7];
        set_nz({v[6:0], cin});
        return {v[6:0], cin};
    endfunction

    function automatic logic [7:0] shift_right(input logic [7:0] v, input logic cin);
        reg_p[c6502_pkg::FLAG_C] = v[0];
        set_nz({cin, v[7:1]});
        return {cin, v[7:1]};
    endfunction

    task automatic predict_operation(input c6502_pkg::t_in_item op);
        c6502_pkg::t_out_item res;
        logic [7:0]           m;
        logic [7:0]           t;
        logic                 carry_in;
        m        = op.operand;
        carry_in = reg_p[c6502_pkg::FLAG_C];
        res      = '0;
        res.write_high = op.address_high;
        case (op.action)
            c6502_pkg::ACT_LDA: begin reg_a = m; set_nz(m); end
            c6502_pkg::ACT_LDX: begin reg_x = m; set_nz(m); end
            c6502_pkg::ACT_LDY: begin reg_y = m; set_nz(m); end
            c6502_pkg::ACT_STA: begin res.write_enable = 1'b1; res.write_data = reg_a; end
            c6502_pkg::ACT_STY: begin res.write_enable = 1'b1; res.write_data = reg_y; end
            c6502_pkg::ACT_STX: begin res.write_enable = 1'b1; res.write_data = reg_x; end
            c6502_pkg::ACT_TAX: begin reg_x = reg_a; set_nz(reg_x); end
            c6502_pkg::ACT_TAY: begin reg_y = reg_a; set_nz(reg_y); end
            c6502_pkg::ACT_TXA: begin reg_a = reg_x; set_nz(reg_a); end
            c6502_pkg::ACT_TYA: begin reg_a = reg_y; set_nz(reg_a); end
            c6502_pkg::ACT_TSX: begin reg_x = reg_s; set_nz(reg_x); end
            c6502_pkg::ACT_TXS: reg_s = reg_x;
            c6502_pkg::ACT_PHA, c6502_pkg::ACT_PHP: begin
                res.write_enable = 1'b1;
                res.stack_access = 1'b1;
                res.stack_slot   = reg_s;
                res.write_data   = (op.action == c6502_pkg::ACT_PHA)
                                   ? reg_a : (reg_p | c6502_pkg::FLAGS_BU);
                reg_s = reg_s - 8'd1;
            end
            c6502_pkg::ACT_PLA, c6502_pkg::ACT_PLP: begin
                reg_s = reg_s + 8'd1;
                res.stack_access = 1'b1;
                res.stack_slot   = reg_s;
                if (op.action == c6502_pkg::ACT_PLA) begin
                    reg_a = m;
                    set_nz(m);
                end else begin
                    reg_p = (reg_p & c6502_pkg::FLAGS_BU) | (m & ~c6502_pkg::FLAGS_BU);
                end
            end
            c6502_pkg::ACT_AND: begin reg_a = reg_a & m; set_nz(reg_a); end
            c6502_pkg::ACT_EOR: begin reg_a = reg_a ^ m; set_nz(reg_a); end
            c6502_pkg::ACT_ORA: begin reg_a = reg_a | m; set_nz(reg_a); end
            c6502_pkg::ACT_BIT: begin
                reg_p[c6502_pkg::FLAG_Z] = ((m & reg_a) == 8'h00);
                reg_p[c6502_pkg::FLAG_N] = m[7];
                reg_p[c6502_pkg::FLAG_V] = m[6];
            end
            c6502_pkg::ACT_ADC: add_with_carry(m);
            c6502_pkg::ACT_SBC: add_with_carry(~m);
            c6502_pkg::ACT_CMP: compare_with(reg_a, m);
            c6502_pkg::ACT_CPX: compare_with(reg_x, m);
            c6502_pkg::ACT_CPY: compare_with(reg_y, m);
            c6502_pkg::ACT_DEC: begin
                res.write_enable = 1'b1;
                res.write_data   = m - 8'd1;
                set_nz(res.write_data);
            end
            c6502_pkg::ACT_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
            c6502_pkg::ACT_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
            c6502_pkg::ACT_INC: begin
                res.write_enable = 1'b1;
                res.write_data   = m + 8'd1;
                set_nz(res.write_data);
            end
            c6502_pkg::ACT_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
            c6502_pkg::ACT_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
            c6502_pkg::ACT_ASL, c6502_pkg::ACT_LSR, c6502_pkg::ACT_ROL,
            c6502_pkg::ACT_ROR: begin
                t = op.on_accumulator ? reg_a : m;
                case (op.action)
                    c6502_pkg::ACT_ASL: t = shift_left(t, 1'b0);
                    c6502_pkg::ACT_LSR: t = shift_right(t, 1'b0);
                    c6502_pkg::ACT_ROL: t = shift_left(t, carry_in);
                    default:            t = shift_right(t, carry_in);
                endcase
                if (op.on_accumulator) begin
                    reg_a = t;
                end else begin
                    res.write_enable = 1'b1;
                    res.write_data   = t;
                end
            end
            c6502_pkg::ACT_BCC: res.branch_taken = !reg_p[c6502_pkg::FLAG_C];
            c6502_pkg::ACT_BCS: res.branch_taken = reg_p[c6502_pkg::FLAG_C];
            c6502_pkg::ACT_BEQ: res.branch_taken = reg_p[c6502_pkg::FLAG_Z];
            c6502_pkg::ACT_BMI: res.branch_taken = reg_p[c6502_pkg::FLAG_N];
            c6502_pkg::ACT_BNE: res.branch_taken = !reg_p[c6502_pkg::FLAG_Z];
            c6502_pkg::ACT_BPL: res.branch_taken = !reg_p[c6502_pkg::FLAG_N];
            c6502_pkg::ACT_BVC: res.branch_taken = !reg_p[c6502_pkg::FLAG_V];
            c6502_pkg::ACT_BVS: res.branch_taken = reg_p[c6502_pkg::FLAG_V];
            c6502_pkg::ACT_CLC: reg_p[c6502_pkg::FLAG_C] = 1'b0;
            c6502_pkg::ACT_CLD: reg_p[c6502_pkg::FLAG_D] = 1'b0;
            c6502_pkg::ACT_CLI: reg_p[c6502_pkg::FLAG_I] = 1'b0;
            c6502_pkg::ACT_CLV: reg_p[c6502_pkg::FLAG_V] = 1'b0;
            c6502_pkg::ACT_SEC: reg_p[c6502_pkg::FLAG_C] = 1'b1;
            c6502_pkg::ACT_SED: reg_p[c6502_pkg::FLAG_D] = 1'b1;
            c6502_pkg::ACT_SEI: reg_p[c6502_pkg::FLAG_I] = 1'b1;
            c6502_pkg::ACT_NOP: ;
            c6502_pkg::ACT_ALR: reg_a = shift_right(reg_a & m, 1'b0);
            c6502_pkg::ACT_ANC: begin
                reg_a = reg_a & m;
                set_nz(reg_a);
                reg_p[c6502_pkg::FLAG_C] = reg_a[7];
            end
            c6502_pkg::ACT_ARR: begin
                t = reg_a & m;
                t = {carry_in, t[7:1]};
                reg_a = t;
                set_nz(t);
                reg_p[c6502_pkg::FLAG_C] = t[6];
                reg_p[c6502_pkg::FLAG_V] = t[6] ^ t[5];
            end
            c6502_pkg::ACT_AXS: begin
                t = reg_x & reg_a;
                compare_with(t, m);
                reg_x = t - m;
            end
            c6502_pkg::ACT_LAX: begin reg_a = m; reg_x = m; set_nz(m); end
            c6502_pkg::ACT_SAX: begin
                res.write_enable = 1'b1;
                res.write_data   = reg_a & reg_x;
            end
            c6502_pkg::ACT_DCP: begin
                res.write_enable = 1'b1;
                res.write_data   = m - 8'd1;
                compare_with(reg_a, res.write_data);
            end
            c6502_pkg::ACT_ISB: begin
                res.write_enable = 1'b1;
                res.write_data   = m + 8'd1;
                add_with_carry(~res.write_data);
            end
            c6502_pkg::ACT_RLA: begin
                res.write_enable = 1'b1;
                res.write_data   = shift_left(m, carry_in);
                reg_a = reg_a & res.write_data;
                set_nz(reg_a);
            end
            c6502_pkg::ACT_RRA: begin
                // The carry out of the rotate feeds the add.
                res.write_enable = 1'b1;
                res.write_data   = shift_right(m, carry_in);
                add_with_carry(res.write_data);
            end
            c6502_pkg::ACT_SLO: begin
                res.write_enable = 1'b1;
                res.write_data   = shift_left(m, 1'b0);
                reg_a = reg_a | res.write_data;
                set_nz(reg_a);
            end
            c6502_pkg::ACT_SRE: begin
                res.write_enable = 1'b1;
                res.write_data   = shift_right(m, 1'b0);
                reg_a = reg_a ^ res.write_data;
                set_nz(reg_a);
            end
            c6502_pkg::ACT_SHY, c6502_pkg::ACT_SHX: begin
                t = (op.action == c6502_pkg::ACT_SHY) ? reg_y : reg_x;
                res.write_enable = 1'b1;
                res.write_data   = t & (op.address_high + 8'd1);
                res.write_high   = res.write_data;
            end
            default: ;
        endcase
        res.accumulator   = reg_a;
        res.index_x       = reg_x;
        res.index_y       = reg_y;
        res.status        = reg_p;
        res.stack_pointer = reg_s;
        if (res.branch_taken) branches_taken++;
        if (res.write_enable) writes_seen++;
        expected_results.push_back(res);
    endtask

    function automatic c6502_pkg::t_in_item make_op(input logic [6:0] act,
                                                    input logic [7:0] m,
                                                    input logic on_acc,
                                                    input logic [7:0] hi);
        c6502_pkg::t_in_item it;
        it.action         = act;
        it.operand        = m;
        it.on_accumulator = on_acc;
        it.address_high   = hi;
        return it;
    endfunction

    // Boundary bytes show up often so that carries, zero and sign all get hit.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return ($urandom_range(0, 1) == 0) ? 8'h7F : 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_operation(in_item);
                codes_seen[in_item.action] = 1'b1;
                ops_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    in_item  <= op_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        c6502_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing outstanding",
                                           results_checked));
                end else begin
                    want = expected_results.pop_front();
                    check_field("accumulator", out_item.accumulator, want.accumulator,
                                results_checked);
                    check_field("index_x", out_item.index_x, want.index_x, results_checked);
                    check_field("index_y", out_item.index_y, want.index_y, results_checked);
                    check_field("status", out_item.status, want.status, results_checked);
                    check_field("stack_pointer", out_item.stack_pointer,
                                want.stack_pointer, results_checked);
                    check_field("write_enable", 8'(out_item.write_enable),
                                8'(want.write_enable), results_checked);
                    check_field("write_data", out_item.write_data, want.write_data,
                                results_checked);
                    check_field("write_high", out_item.write_high, want.write_high,
                                results_checked);
                    check_field("stack_access", 8'(out_item.stack_access),
                                8'(want.stack_access), results_checked);
                    check_field("stack_slot", out_item.stack_slot, want.stack_slot,
                                results_checked);
                    check_field("branch_taken", 8'(out_item.branch_taken),
                                8'(want.branch_taken), results_checked);
                end
                results_checked++;
            end
            // The stall mode rotates: free flow, light, heavy and a long periodic hold.
            case ((stall_cycle / 300) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((stall_cycle % 10) < 7);
            endcase
            stall_cycle++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("[cpu6502_execute_unit] ERROR");
            $finish;
        end
    end

    initial begin
        int         issued;
        logic [6:0] act;
        reg_a = 8'h00;
        reg_x = 8'h00;
        reg_y = 8'h00;
        reg_p = c6502_pkg::STATUS_RESET;
        reg_s = c6502_pkg::STACK_RESET;

        // Directed: flag extremes, overflow, stack wrap, PHP/PLP bit rules,
        // SHX/SHY address carry, shifts both ways, unused codes.
        op_queue.push_back(make_op(c6502_pkg::ACT_LDA, 8'h00, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_LDA, 8'hFF, 1'b1, 8'hFF));
        op_queue.push_back(make_op(c6502_pkg::ACT_ADC, 8'h80, 1'b0, 8'h12));
        op_queue.push_back(make_op(c6502_pkg::ACT_SBC, 8'h7F, 1'b0, 8'h34));
        op_queue.push_back(make_op(c6502_pkg::ACT_BVS, 8'h00, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_PHP, 8'h00, 1'b0, 8'h01));
        op_queue.push_back(make_op(c6502_pkg::ACT_PLP, 8'hFF, 1'b0, 8'h01));
        op_queue.push_back(make_op(c6502_pkg::ACT_PHP, 8'h00, 1'b0, 8'h01));
        op_queue.push_back(make_op(c6502_pkg::ACT_PLP, 8'h00, 1'b0, 8'h01));
        op_queue.push_back(make_op(c6502_pkg::ACT_LDX, 8'h00, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_TXS, 8'h00, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_PHA, 8'h00, 1'b0, 8'h01));
        op_queue.push_back(make_op(c6502_pkg::ACT_PLA, 8'h80, 1'b0, 8'h01));
        op_queue.push_back(make_op(c6502_pkg::ACT_LDX, 8'hFF, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_TXS, 8'h00, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_PLA, 8'h00, 1'b0, 8'h01));
        op_queue.push_back(make_op(c6502_pkg::ACT_SHX, 8'h00, 1'b0, 8'hFF));
        op_queue.push_back(make_op(c6502_pkg::ACT_SHX, 8'h00, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_LDY, 8'hAA, 1'b0, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_SHY, 8'h00, 1'b0, 8'h7F));
        op_queue.push_back(make_op(c6502_pkg::ACT_ROR, 8'h55, 1'b1, 8'h00));
        op_queue.push_back(make_op(c6502_pkg::ACT_ASL, 8'h80, 1'b0, 8'hC0));
        op_queue.push_back(make_op(c6502_pkg::ACT_NOP, 8'hFF, 1'b1, 8'hFF));
        op_queue.push_back(make_op(ACT_UNUSED_LOW, 8'hFF, 1'b1, 8'hFF));
        op_queue.push_back(make_op(ACT_UNUSED_TOP, 8'hFF, 1'b1, 8'hFF));
        directed_ops = op_queue.size();

        // Random: mostly real operations; unused codes are extra and not counted.
        issued = 0;
        while (issued < RANDOM_OPS) begin
            if ($urandom_range(0, 19) == 0) begin
                act = 7'($urandom_range(ACT_UNUSED_LOW, ACT_UNUSED_TOP));
            end else begin
                act = 7'($urandom_range(c6502_pkg::ACT_LDA, c6502_pkg::ACT_SHX));
                issued++;
            end
            op_queue.push_back(make_op(act, random_byte(), 1'($urandom), random_byte()));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || in_valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d operations (%0d directed, %0d of 65 defined codes), %0d results.",
                 ops_accepted, directed_ops, $countones(codes_seen[64:0]), results_checked);
        $display("Of these %0d took a branch and %0d wrote memory or stack; %0d mismatches.",
                 branches_taken, writes_seen, errors);
        if (errors == 0) begin
            $display("[cpu6502_execute_unit] OK");
        end else begin
            $display("[cpu6502_execute_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/c6502_pkg.sv
rtl/c6502_regs.sv
rtl/c6502_alu.sv
rtl/cpu6502_execute_unit.sv
bench/cpu6502_execute_unit_test.sv
